[hdl/polyblep_oscillator_macros.svh]
// assertion helpers for the oscillator top level
`ifndef POLYBLEP_OSCILLATOR_MACROS_SVH
`define POLYBLEP_OSCILLATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define PBLEP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("oscillator check failed");

// next-cycle implication, checked outside reset
`define PBLEP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("oscillator check failed");

`endif

[hdl/pblep_pkg.sv]
package pblep_pkg;

  localparam int FRAC   = 20;
  localparam int MUL_W  = 33;
  localparam int QUO_W  = 22;
  localparam int VAL_W  = 26;
  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_WAVEFORM  = 3'd0;
  localparam logic [2:0] REG_AMPLITUDE = 3'd1;
  localparam logic [2:0] REG_DUTY      = 3'd2;
  localparam logic [2:0] REG_PITCH     = 3'd3;
  localparam logic [2:0] REG_STEP_HZ   = 3'd4;

  localparam logic [2:0] WAVE_SAW      = 3'd0;
  localparam logic [2:0] WAVE_SINE     = 3'd1;
  localparam logic [2:0] WAVE_SQUARE   = 3'd2;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
  localparam logic [2:0] WAVE_NOISE    = 3'd4;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [63:0] PI_Q30_W    = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [31:0] LFSR_SEED   = 32'd2654435761;
  localparam logic [14:0] NOISE_DEN   = 15'd32767;
  localparam logic [16:0] NOISE_MUL   = 17'd65538;
  localparam logic signed [38:0] NOISE_OFS = 39'sd34357641216;  // 32766 << 20
  localparam logic signed [VAL_W-1:0] ONE_V = 26'sd1048576;

  // one table entry of 32767*sin(2*pi*i/2^log2n) by a truncated odd series
  function automatic logic signed [15:0] sine_entry(int unsigned i, int unsigned log2n);
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] s;
    logic signed [63:0] val;
    logic neg;
    int unsigned k;
    x = (64'(i) * TWO_PI_Q30) >> log2n;
    neg = 1'b0;
    if (x >= PI_Q30_W) begin
      x = x - PI_Q30_W;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q30) x = PI_Q30_W - x;
    s = signed'(x);
    term = x;
    for (k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) s = s - signed'(term);
      else s = s + signed'(term);
    end
    if (s < 0) s = 0;
    val = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (val > 32767) val = 32767;
    return 16'(neg ? -val : val);
  endfunction

endpackage

[hdl/polyblep_oscillator.sv]
// requests are taken one at a time, only while idle; a restart request clears
// phase and integrator and gives no sample; each PolyBLEP edge costs one pass of
// the shared divider, which saw, square and triangle wait for
// reset: registers take their defaults, phase and integrator clear, noise seed reloads
`include "polyblep_oscillator_macros.svh"
module polyblep_oscillator #(
  parameter int SINE_ENTRIES = 2048,
  parameter int PHASE_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pblep_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [23:0]                   frequency,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            sample
);
  import pblep_pkg::*;

  localparam int PB     = PHASE_BITS;
  localparam int SLOG   = $clog2(SINE_ENTRIES);
  localparam int NUM_W  = PB + FRAC;
  localparam int P_W    = 2 * MUL_W;

  typedef enum logic [4:0] {
    S_IDLE, S_STEP0, S_STEP1, S_STEP2, S_STEP3,
    S_B0, S_B1, S_B2, S_T0, S_T1, S_T2,
    S_S0, S_S1, S_S2, S_S3, S_N0, S_N1, S_N2,
    S_SC0, S_SC1, S_OUT
  } state_t;

  state_t state;

  logic [2:0]  waveform;
  logic [15:0] amplitude;
  logic [15:0] duty_cycle;
  logic [23:0] pitch_multiplier;
  logic [31:0] step_per_hz;

  logic [PB-1:0]           phase;
  logic signed [23:0]      integ;
  logic [31:0]             lfsr;
  logic [23:0]             freq_q;
  logic [15:0]             a_hi;
  logic [63:0]             acc;
  logic [PB-1:0]           step;
  logic [PB-1:0]           t_cur;
  logic signed [VAL_W-1:0] v;
  logic signed [15:0]      y0;
  logic signed [15:0]      res;
  logic                    pass;
  logic                    blep_sub;
  logic                    blep_lo;
  logic                    blep_none;
  logic                    noise_neg;
  logic [23:0]             nq1;
  logic [24:0]             nr1;

  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [P_W-1:0]   p;
  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic                    div_busy;
  logic                    div_done;
  logic [QUO_W-1:0]        div_quo;
  logic [SLOG:0]           rom_addr;
  logic signed [15:0]      rom_rdata;

  logic                    wr_en;
  logic [2:0]              reg_idx;
  logic                    t_lo;
  logic                    t_hi;
  logic [PB:0]             t_sum;
  logic [PB:0]             one_minus_t;
  logic [20:0]             blep_d;
  logic [20:0]             blep_mag;
  logic [79:0]             step_full;
  logic [PB+SLOG-1:0]      phase_sh;
  logic [SLOG-1:0]         sine_idx;
  logic [FRAC-1:0]         sine_frac;
  logic signed [16:0]      sine_diff;
  logic [31:0]             s1;
  logic [31:0]             s2;
  logic [31:0]             s3;
  logic signed [38:0]      noise_n;
  logic [38:0]             noise_mag;
  logic [9:0]              nq2;
  logic [15:0]             nr2;
  logic [23:0]             noise_q;
  logic signed [VAL_W-1:0] tri_diff;
  logic signed [31:0]      tri_sum;
  logic signed [23:0]      tri_sat;
  logic signed [P_W-1:0]   scaled;
  logic signed [15:0]      sat_out;
  logic                    sq_high;

  pblep_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  pblep_div #(.NUM_W(NUM_W), .DEN_W(PB), .QW(QUO_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num),
    .den(step),
    .busy(div_busy), .done(div_done), .quo(div_quo)
  );

  pblep_rom #(.LOG(SLOG)) u_rom (.clk(clk), .addr(rom_addr), .rdata(rom_rdata));

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      REG_WAVEFORM:  prdata = 32'(waveform);
      REG_AMPLITUDE: prdata = 32'(amplitude);
      REG_DUTY:      prdata = 32'(duty_cycle);
      REG_PITCH:     prdata = 32'(pitch_multiplier);
      REG_STEP_HZ:   prdata = step_per_hz;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform         <= WAVE_SAW;
      amplitude        <= 16'd16384;
      duty_cycle       <= 16'd32768;
      pitch_multiplier <= 24'd65536;
      step_per_hz      <= 32'd22906492;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WAVEFORM:  waveform         <= pwdata[2:0];
        REG_AMPLITUDE: amplitude        <= pwdata[15:0];
        REG_DUTY:      duty_cycle       <= pwdata[15:0];
        REG_PITCH:     pitch_multiplier <= pwdata[23:0];
        REG_STEP_HZ:   step_per_hz      <= pwdata;
        default:       ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  // datapath helpers
  always_comb begin
    t_sum       = {1'b0, t_cur} + {1'b0, step};
    t_lo        = t_cur < step;
    t_hi        = t_sum > {1'b1, {PB{1'b0}}};
    one_minus_t = {1'b1, {PB{1'b0}}} - {1'b0, t_cur};
    blep_d      = 21'd1048576 - 21'(div_quo);
    blep_mag    = blep_none ? 21'd0 : p[40:20];
    step_full   = {16'd0, acc} + {p[47:0], 32'd0};
    phase_sh    = {phase, {SLOG{1'b0}}};
    sine_idx    = phase[PB-1 -: SLOG];
    sine_frac   = phase_sh[PB-1 -: FRAC];
    sine_diff   = 17'(rom_rdata) - 17'(y0);
    s1          = lfsr ^ (lfsr << 13);
    s2          = s1 ^ (s1 >> 17);
    s3          = s2 ^ (s2 << 5);
    noise_n     = signed'({2'b00, p[48:12]}) - NOISE_OFS;
    noise_mag   = noise_n[38] ? 39'(-noise_n) + 39'd32766 : 39'(noise_n);
    // second fold of the divide by 2^15-1, then one compare that adds one to the quotient
    nq2         = nr1[24:15];
    nr2         = 16'(nr1[14:0]) + 16'(nq2);
    noise_q     = 24'(nq1) + 24'(nq2) + 24'(nr2 >= 16'(NOISE_DEN));
    tri_diff    = v - VAL_W'(integ);
    tri_sum     = 32'(integ) + 32'(p >>> FRAC);
    if (tri_sum > 32'sd8388607) tri_sat = 24'sd8388607;
    else if (tri_sum < -32'sd8388608) tri_sat = -24'sd8388608;
    else tri_sat = 24'(tri_sum);
    scaled = p >>> FRAC;
    if (scaled > P_W'(32767)) sat_out = 16'sd32767;
    else if (scaled < -P_W'(32768)) sat_out = -16'sd32768;
    else sat_out = 16'(scaled);
    sq_high = phase <= {duty_cycle, {(PB-16){1'b0}}};
  end

  // operand selection for the shared multiplier, divider and table
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    rom_addr  = {1'b0, sine_idx};
    case (state)
      S_STEP0: begin
        mul_a = MUL_W'(freq_q);
        mul_b = MUL_W'(pitch_multiplier);
      end
      S_STEP1: begin
        mul_a = MUL_W'(p[31:0]);
        mul_b = MUL_W'(step_per_hz);
      end
      S_STEP2: begin
        mul_a = MUL_W'(a_hi);
        mul_b = MUL_W'(step_per_hz);
      end
      S_B0: begin
        if (t_lo) begin
          div_start = 1'b1;
          div_num   = {t_cur, {FRAC{1'b0}}};
        end else if (t_hi) begin
          div_start = 1'b1;
          div_num   = {one_minus_t[PB-1:0], {FRAC{1'b0}}};
        end
      end
      S_B1: begin
        mul_a = MUL_W'(blep_d);
        mul_b = MUL_W'(blep_d);
      end
      S_T0: begin
        mul_a = MUL_W'(step[PB-1 -: FRAC]);
        mul_b = MUL_W'(PI_Q30);
      end
      S_T1: begin
        mul_a = MUL_W'(p[51:29]);
        mul_b = MUL_W'(tri_diff);
      end
      S_S1: rom_addr = {1'b0, sine_idx} + 1'b1;
      S_S2: begin
        mul_a = MUL_W'(sine_diff);
        mul_b = MUL_W'(sine_frac);
      end
      S_N0: begin
        mul_a = MUL_W'(s3);
        mul_b = MUL_W'(NOISE_MUL);
      end
      S_SC0: begin
        mul_a = MUL_W'(v);
        mul_b = MUL_W'(amplitude);
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      phase     <= '0;
      integ     <= '0;
      lfsr      <= LFSR_SEED;
    end else begin
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (mode) begin
              phase <= '0;
              integ <= '0;
            end else begin
              freq_q <= frequency;
              state  <= S_STEP0;
            end
          end
        end
        S_STEP0: state <= S_STEP1;
        S_STEP1: begin
          a_hi  <= p[47:32];
          state <= S_STEP2;
        end
        S_STEP2: begin
          acc   <= p[63:0];
          state <= S_STEP3;
        end
        S_STEP3: begin
          step  <= step_full[64-PB +: PB];
          t_cur <= phase;
          pass  <= 1'b0;
          case (waveform)
            WAVE_SAW: begin
              v        <= ONE_V - signed'(VAL_W'({phase[PB-1 -: FRAC], 1'b0}));
              blep_sub <= 1'b1;
              state    <= S_B0;
            end
            WAVE_SINE: state <= S_S0;
            WAVE_SQUARE, WAVE_TRIANGLE: begin
              v        <= sq_high ? ONE_V : -ONE_V;
              blep_sub <= 1'b0;
              state    <= S_B0;
            end
            WAVE_NOISE: state <= S_N0;
            default: begin
              v     <= '0;
              state <= S_SC0;
            end
          endcase
        end
        S_B0: begin
          blep_lo   <= t_lo;
          blep_none <= !(t_lo || t_hi);
          state     <= (t_lo || t_hi) ? S_B1 : S_B2;
        end
        S_B1: begin
          if (div_done) state <= S_B2;
        end
        S_B2: begin
          // lower branch adds the magnitude when blep_sub is set, else subtracts it; upper is the reverse
          if (blep_lo == blep_sub) v <= v + VAL_W'(blep_mag);
          else v <= v - VAL_W'(blep_mag);
          if ((waveform == WAVE_SQUARE || waveform == WAVE_TRIANGLE) && !pass) begin
            pass     <= 1'b1;
            t_cur    <= phase + {1'b1, {(PB-1){1'b0}}};
            blep_sub <= 1'b1;
            state    <= S_B0;
          end else if (waveform == WAVE_TRIANGLE) begin
            state <= S_T0;
          end else begin
            state <= S_SC0;
          end
        end
        S_T0: state <= S_T1;
        S_T1: state <= S_T2;
        S_T2: begin
          integ <= tri_sat;
          v     <= VAL_W'(tri_sat);
          state <= S_SC0;
        end
        S_S0: state <= S_S1;
        S_S1: begin
          y0    <= rom_rdata;
          state <= S_S2;
        end
        S_S2: state <= S_S3;
        S_S3: begin
          v     <= (VAL_W'(y0) <<< 5) + VAL_W'(p >>> 15);
          state <= S_SC0;
        end
        S_N0: begin
          lfsr  <= s3;
          state <= S_N1;
        end
        S_N1: begin
          // first fold: x = hi*2^15 + lo gives hi*(2^15-1) + (hi+lo)
          noise_neg <= noise_n[38];
          nq1       <= noise_mag[38:15];
          nr1       <= 25'(noise_mag[14:0]) + 25'(noise_mag[38:15]);
          state     <= S_N2;
        end
        S_N2: begin
          v     <= noise_neg ? -VAL_W'(noise_q) : VAL_W'(noise_q);
          state <= S_SC0;
        end
        S_SC0: state <= S_SC1;
        S_SC1: begin
          res   <= sat_out;
          phase <= phase + step;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            sample    <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PBLEP_ASSERT_IMPL(a_div_free, div_start, !div_busy)
  `PBLEP_ASSERT_NEXT(a_phase_hold, (state != S_SC1) && !(in_valid && in_ready), $stable(phase))
  `PBLEP_ASSERT_NEXT(a_integ_hold, (state != S_T2) && !(in_valid && in_ready), $stable(integ))

endmodule

[hdl/pblep_div.sv]
module pblep_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 32,
  parameter int QW    = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [QW-1:0]    quo
);
  localparam int CNT_W = $clog2(QW + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [QW-1:0]    low;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             fit;

  // restoring division, one quotient bit a cycle
  assign trial = {rem, low[QW-1]};
  assign fit   = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= DEN_W'(num >> QW);
        low   <= num[QW-1:0];
        den_q <= den;
        quo   <= '0;
        cnt   <= CNT_W'(QW);
        busy  <= 1'b1;
      end else if (busy) begin
        rem <= fit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        low <= low << 1;
        quo <= {quo[QW-2:0], fit};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[hdl/pblep_mul.sv]
module pblep_mul (
  input  logic                                   clk,
  input  logic signed [pblep_pkg::MUL_W-1:0]     a,
  input  logic signed [pblep_pkg::MUL_W-1:0]     b,
  output logic signed [2*pblep_pkg::MUL_W-1:0]   p
);
  import pblep_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

[hdl/pblep_rom.sv]
module pblep_rom #(
  parameter int LOG = 11
) (
  input  logic               clk,
  input  logic [LOG:0]       addr,
  output logic signed [15:0] rdata
);
  import pblep_pkg::*;

  localparam int N = 1 << LOG;

  typedef logic signed [15:0] rom_t [N+1];

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < N; i++) r[i] = sine_entry(i, LOG);
    r[N] = r[0];
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    rdata <= ROM[addr];
  end
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  import pblep_pkg::*;

  typedef struct packed {
    logic        mode;
    logic [23:0] freq;
  } osc_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic mode = 1'b0;
  logic [23:0] frequency = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [15:0] sample;

  polyblep_oscillator u_top (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .frequency(frequency),
    .out_valid(out_valid), .out_ready(out_ready), .sample(sample)
  );

  localparam longint ONE = 64'sd1 << 20;

  osc_req_t req_q[$];
  logic signed [15:0] sample_q[$];
  osc_req_t next_req;
  int fails = 0;
  int send_idle = 0;
  int recv_stall = 0;
  bit req_taken = 1'b0;

  // shadow registers and oscillator state
  logic [2:0]  wave_sel = WAVE_SAW;
  logic [15:0] amp_gain = 16'd16384;
  logic [15:0] duty = 16'd32768;
  logic [23:0] pitch = 24'd65536;
  logic [31:0] hz_step = 32'd22906492;
  logic [31:0] phase = '0;
  longint integ = 0;
  logic [31:0] lfsr = LFSR_SEED;
  longint sine_tab[0:2048];

  initial begin : build_table
    longint unsigned x, term;
    longint s, val;
    bit neg;
    for (int i = 0; i < 2048; i++) begin
      x = (longint'(i) * 64'd6746518852) / 2048;
      neg = 1'b0;
      if (x >= 64'd3373259426) begin
        x = x - 64'd3373259426;
        neg = 1'b1;
      end
      if (x > 64'd1686629713) x = 64'd3373259426 - x;
      s = x;
      term = x;
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) s = s - longint'(term);
        else s = s + longint'(term);
      end
      if (s < 0) s = 0;
      val = (s * 32767 + (64'sd1 << 29)) >>> 30;
      if (val > 32767) val = 32767;
      sine_tab[i] = neg ? -val : val;
    end
    sine_tab[2048] = sine_tab[0];
  end

  initial forever #4 clk = ~clk;

  function automatic longint blep_corr(logic [63:0] t, logic [63:0] dt);
    longint d;
    if (t < dt) begin
      d = ONE - longint'((t << 20) / dt);
      return -((d * d) >>> 20);
    end
    if (t + dt > 64'h1_0000_0000) begin
      d = ONE - longint'(((64'h1_0000_0000 - t) << 20) / dt);
      return (d * d) >>> 20;
    end
    return 0;
  endfunction

  function automatic longint square_val(logic [31:0] st);
    longint v;
    v = ({16'd0, phase, 16'd0} <= {16'd0, duty, 32'd0}) ? ONE : -ONE;
    v += blep_corr(phase, st);
    v -= blep_corr(32'(phase + 32'h8000_0000), st);
    return v;
  endfunction

  task automatic predict_sample(input osc_req_t r);
    logic [127:0] prod;
    logic [31:0] st;
    logic [63:0] idx;
    longint v, c, fr, y0, y1, n, o;
    if (r.mode) begin
      phase = '0;
      integ = 0;
    end else begin
      prod = 128'(r.freq) * 128'(pitch) * 128'(hz_step);
      st = prod[63:32];
      case (wave_sel)
        WAVE_SAW: v = ONE - 2 * longint'(phase >> 12) - blep_corr(phase, st);
        WAVE_SINE: begin
          idx = 64'(phase) * 2048;
          y0 = sine_tab[idx[42:32]];
          y1 = sine_tab[idx[42:32] + 1];
          fr = idx[31:12];
          v = y0 * 32 + (((y1 - y0) * fr) >>> 15);
        end
        WAVE_SQUARE: v = square_val(st);
        WAVE_TRIANGLE: begin
          c = longint'((64'(st >> 12) * 64'd3373259426) >> 29);
          v = integ + ((c * (square_val(st) - integ)) >>> 20);
          if (v > 8388607) v = 8388607;
          if (v < -8388608) v = -8388608;
          integ = v;
        end
        WAVE_NOISE: begin
          lfsr ^= lfsr << 13;
          lfsr ^= lfsr >> 17;
          lfsr ^= lfsr << 5;
          n = longint'((64'd65538 * 64'(lfsr)) >> 12) - (64'sd32766 << 20);
          v = (n >= 0) ? n / 32767 : -((-n + 32766) / 32767);
        end
        default: v = 0;
      endcase
      o = (v * longint'(amp_gain)) >>> 20;
      if (o > 32767) o = 32767;
      if (o < -32768) o = -32768;
      sample_q.push_back(16'(o));
      phase = phase + st;
    end
  endtask

  // acceptance and result check
  always @(posedge clk) begin
    req_taken = !rst && in_valid && in_ready;
    if (req_taken) predict_sample('{mode, frequency});
    if (!rst && out_valid && out_ready) begin
      if (sample_q.size() == 0) begin
        $display("%0t: unexpected sample, expected none, actual %0d", $time, sample);
        fails++;
      end else begin
        if (sample !== sample_q[0]) begin
          $display("%0t: sample mismatch, expected %0d, actual %0d",
                   $time, sample_q[0], sample);
          fails++;
        end
        void'(sample_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        next_req = req_q.pop_front();
        in_valid <= 1'b1;
        mode <= next_req.mode;
        frequency <= next_req.freq;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic drain();
    while (req_q.size() > 0 || in_valid || sample_q.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WAVEFORM:  wave_sel = val[2:0];
      REG_AMPLITUDE: amp_gain = val[15:0];
      REG_DUTY:      duty = val[15:0];
      REG_PITCH:     pitch = val[23:0];
      REG_STEP_HZ:   hz_step = val;
      default: ;
    endcase
  endtask

  task automatic add_req(input logic m, input logic [23:0] f);
    req_q.push_back('{m, f});
  endtask

  initial begin : stimulus
    logic [31:0] amp_v, duty_v, pitch_v, hz_v;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: saw at reset settings, frequency extremes, restart
    add_req(1'b0, 24'd0);
    add_req(1'b0, 24'd112640);
    add_req(1'b0, 24'd112640);
    add_req(1'b0, 24'hFFFFFF);
    add_req(1'b1, 24'hFFFFFF);
    add_req(1'b0, 24'd112640);
    drain();
    for (int w = 1; w <= 7; w++) begin
      reg_write(REG_WAVEFORM, w);
      add_req(1'b0, 24'd112640);
      add_req(1'b0, 24'd5000000);
      if (w == 3) add_req(1'b1, 24'd0);
      add_req(1'b0, 24'hFFFFFF);
      drain();
    end
    for (int ph = 0; ph < 18; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 75; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 75; end
        default: begin send_idle = 22; recv_stall = 22; end
      endcase
      amp_v = (ph == 1) ? 0 : (ph == 2) ? 32768 : (ph == 3) ? 65535 : $urandom_range(32768);
      duty_v = (ph == 4) ? 0 : (ph == 5) ? 65535 : $urandom_range(65535);
      pitch_v = (ph == 6) ? 0 : (ph == 7) ? 24'hFFFFFF : $urandom_range(262143, 16384);
      hz_v = (ph == 8) ? 0 : (ph == 9) ? 32'hFFFFFFFF : $urandom_range(90000000, 5000000);
      reg_write(REG_WAVEFORM, (ph * 3) % 8);
      reg_write(REG_AMPLITUDE, amp_v);
      reg_write(REG_DUTY, duty_v);
      reg_write(REG_PITCH, pitch_v);
      reg_write(REG_STEP_HZ, hz_v);
      for (int i = 0; i < 25; i++) begin
        if ($urandom_range(7) == 0) add_req(1'b0, $urandom_range(24'hFFFFFF));
        else add_req($urandom_range(15) == 0, $urandom_range(2000000, 2000));
      end
      // next phase's register writes wait until every pending sample is back
      drain();
    end
    if (fails == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/pblep_pkg.sv
hdl/pblep_div.sv
hdl/pblep_mul.sv
hdl/pblep_rom.sv
hdl/polyblep_oscillator.sv
tb/sv/testbench.sv
